### hw/rtl/lpfp_pkg.sv
// ----------------------------------------------------------------------------
// lpfp_pkg
// types and constants shared by the length prefixed frame parser
// ----------------------------------------------------------------------------
package lpfp_pkg;

   localparam int MaxTokensDefault = 16;
   localparam logic [30:0] LengthLimitReset = 31'h7fff_ffff;

   // framing characters
   localparam logic [7:0] CharHash  = 8'h23;
   localparam logic [7:0] CharCaret = 8'h5e;
   localparam logic [7:0] CharAmp   = 8'h26;
   localparam logic [7:0] CharCr    = 8'h0d;
   localparam logic [7:0] CharLf    = 8'h0a;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR_DIGITS,
      PH_HDR_LF,
      PH_TOK_MARK,
      PH_TOK_DIGITS,
      PH_TOK_DATA,
      PH_END_LF,
      PH_ERROR
   } phase_type;

   typedef enum logic [2:0] {
      EV_FRAMING    = 3'd0,
      EV_TOKEN_DATA = 3'd1,
      EV_EMPTY_TOK  = 3'd2,
      EV_FRAME_DONE = 3'd3,
      EV_ERROR      = 3'd4
   } event_type;

   typedef enum logic [3:0] {
      ERR_NONE          = 4'd0,
      ERR_BAD_START     = 4'd1,
      ERR_NO_DIGITS     = 4'd2,
      ERR_OVER_LIMIT    = 4'd3,
      ERR_BAD_HDR_END   = 4'd4,
      ERR_BODY_SHORT    = 4'd5,
      ERR_BAD_TOK_MARK  = 4'd6,
      ERR_TOK_TRUNC     = 4'd7,
      ERR_TOK_PAST_BODY = 4'd8,
      ERR_TOO_MANY_TOKS = 4'd9,
      ERR_BAD_FRAME_END = 4'd10
   } err_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] token_byte;
      logic [7:0] token_index;
      logic       token_end;
      logic [8:0] token_count;
      logic [3:0] error_code;
   } rsp_type;

endpackage

### hw/rtl/length_prefixed_frame_parser_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_core
// byte-wide parser for '#' <len> CR LF { '^' <len> '&' <data> } CR LF frames
// ----------------------------------------------------------------------------
// path: req word into the input register, rsp word from the result register
// throughput: one word per cycle while not stalled; the parse state update
//   is a single pass of logic between the input and result registers
// reset: synchronous, active high; parser returns to waiting for '#',
//   length_limit returns to its maximum, both word registers empty
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_core
   import lpfp_pkg::*;
#(
   parameter int MAX_TOKENS = MaxTokensDefault
) (
   input  logic        clock,
   input  logic        reset,
   // request words, one stream byte each
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   // response words, one per request word
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   // length limit register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_data
);

   localparam logic [8:0] MaxTokensC = 9'(MAX_TOKENS);

   // configuration
   logic [30:0] limit_ff;

   // pipeline registers
   logic        in_valid_ff;
   req_type     in_word_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_word_ff;
   rsp_type     rsp_word_in;

   // parse state
   phase_type   phase_ff, phase_in;
   logic [30:0] acc_ff, acc_in;
   logic        seen_ff, seen_in;
   logic [30:0] body_ff, body_in;
   logic [30:0] tok_left_ff, tok_left_in;
   logic [8:0]  count_ff, count_in;

   logic        advance;
   logic        step;

   // the result stage moves when it is empty or its word is taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;
   assign csr_ready = 1'b1;

   // ---------------- input register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_word_ff <= req_data;
      end
   end

   // ---------------- parse logic ----------------
   logic [7:0]  b;
   logic        is_digit;
   logic [34:0] digit_sum;
   logic        over_limit;
   logic [30:0] body_dec;
   logic [30:0] tok_dec;
   phase_type   cur_phase;

   assign b         = in_word_ff.data_byte;
   assign is_digit  = (b >= CharZero) && (b <= CharNine);
   // acc * 10 + digit, as shift-adds
   assign digit_sum = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                      + {31'd0, b[3:0]};
   assign over_limit = digit_sum > {4'd0, limit_ff};
   assign body_dec   = body_ff - 31'd1;
   assign tok_dec    = tok_left_ff - 31'd1;
   // restart forces this byte to be parsed as a frame start
   assign cur_phase  = in_word_ff.restart ? PH_IDLE : phase_ff;

   always_comb begin
      phase_in    = cur_phase;
      acc_in      = acc_ff;
      seen_in     = seen_ff;
      body_in     = body_ff;
      tok_left_in = tok_left_ff;
      count_in    = count_ff;
      rsp_word_in = '0;

      unique case (cur_phase)
         PH_IDLE: begin
            if (b != CharHash) begin
               phase_in               = PH_ERROR;
               rsp_word_in.event_res  = EV_ERROR;
               rsp_word_in.error_code = ERR_BAD_START;
            end else begin
               acc_in   = '0;
               seen_in  = 1'b0;
               phase_in = PH_HDR_DIGITS;
            end
         end

         PH_HDR_DIGITS: begin
            if (is_digit) begin
               if (over_limit) begin
                  phase_in               = PH_ERROR;
                  rsp_word_in.event_res  = EV_ERROR;
                  rsp_word_in.error_code = ERR_OVER_LIMIT;
               end else begin
                  acc_in  = digit_sum[30:0];
                  seen_in = 1'b1;
               end
            end else if (!seen_ff) begin
               phase_in               = PH_ERROR;
               rsp_word_in.event_res  = EV_ERROR;
               rsp_word_in.error_code = ERR_NO_DIGITS;
            end else if (b != CharCr) begin
               phase_in               = PH_ERROR;
               rsp_word_in.event_res  = EV_ERROR;
               rsp_word_in.error_code = ERR_BAD_HDR_END;
            end else begin
               phase_in = PH_HDR_LF;
            end
         end

         PH_HDR_LF: begin
            if (b != CharLf) begin
               phase_in               = PH_ERROR;
               rsp_word_in.event_res  = EV_ERROR;
               rsp_word_in.error_code = ERR_BAD_HDR_END;
            end else if (acc_ff < 31'd2) begin
               // body must at least hold the closing CR LF
               phase_in               = PH_ERROR;
               rsp_word_in.event_res  = EV_ERROR;
               rsp_word_in.error_code = ERR_BODY_SHORT;
            end else begin
               body_in  = acc_ff;
               count_in = '0;
               phase_in = PH_TOK_MARK;
            end
         end

         PH_TOK_MARK: begin
            if (body_ff <= 31'd2) begin
               // only the closing CR LF remains
               if (b != CharCr) begin
                  phase_in               = PH_ERROR;
                  rsp_word_in.event_res  = EV_ERROR;
                  rsp_word_in.error_code = ERR_BAD_FRAME_END;
               end else begin
                  body_in  = 31'd1;
                  phase_in = PH_END_LF;
               end
            end else if (b != CharCaret) begin
               phase_in               = PH_ERROR;
               rsp_word_in.event_res  = EV_ERROR;
               rsp_word_in.error_code = ERR_BAD_TOK_MARK;
            end else begin
               body_in  = body_dec;
               acc_in   = '0;
               seen_in  = 1'b0;
               phase_in = PH_TOK_DIGITS;
            end
         end

         PH_TOK_DIGITS: begin
            if (body_ff <= 31'd2) begin
               // token header ran into the closing CR LF
               phase_in               = PH_ERROR;
               rsp_word_in.event_res  = EV_ERROR;
               rsp_word_in.error_code = seen_ff ? ERR_TOK_TRUNC : ERR_NO_DIGITS;
            end else if (is_digit) begin
               if (over_limit) begin
                  phase_in               = PH_ERROR;
                  rsp_word_in.event_res  = EV_ERROR;
                  rsp_word_in.error_code = ERR_OVER_LIMIT;
               end else begin
                  acc_in  = digit_sum[30:0];
                  seen_in = 1'b1;
                  body_in = body_dec;
               end
            end else if (!seen_ff) begin
               phase_in               = PH_ERROR;
               rsp_word_in.event_res  = EV_ERROR;
               rsp_word_in.error_code = ERR_NO_DIGITS;
            end else if (b != CharAmp) begin
               phase_in               = PH_ERROR;
               rsp_word_in.event_res  = EV_ERROR;
               rsp_word_in.error_code = ERR_BAD_TOK_MARK;
            end else begin
               body_in = body_dec;
               if (acc_ff > body_dec - 31'd2) begin
                  phase_in               = PH_ERROR;
                  rsp_word_in.event_res  = EV_ERROR;
                  rsp_word_in.error_code = ERR_TOK_PAST_BODY;
               end else if (count_ff >= MaxTokensC) begin
                  phase_in               = PH_ERROR;
                  rsp_word_in.event_res  = EV_ERROR;
                  rsp_word_in.error_code = ERR_TOO_MANY_TOKS;
               end else begin
                  tok_left_in = acc_ff;
                  if (acc_ff == '0) begin
                     rsp_word_in.event_res   = EV_EMPTY_TOK;
                     rsp_word_in.token_index = count_ff[7:0];
                     count_in                = count_ff + 9'd1;
                     phase_in                = PH_TOK_MARK;
                  end else begin
                     phase_in = PH_TOK_DATA;
                  end
               end
            end
         end

         PH_TOK_DATA: begin
            tok_left_in             = tok_dec;
            body_in                 = body_dec;
            rsp_word_in.event_res   = EV_TOKEN_DATA;
            rsp_word_in.token_byte  = b;
            rsp_word_in.token_index = count_ff[7:0];
            if (tok_dec == '0) begin
               rsp_word_in.token_end = 1'b1;
               count_in              = count_ff + 9'd1;
               phase_in              = PH_TOK_MARK;
            end
         end

         PH_END_LF: begin
            if (b != CharLf) begin
               phase_in               = PH_ERROR;
               rsp_word_in.event_res  = EV_ERROR;
               rsp_word_in.error_code = ERR_BAD_FRAME_END;
            end else begin
               body_in                 = '0;
               rsp_word_in.event_res   = EV_FRAME_DONE;
               rsp_word_in.token_count = count_ff;
               phase_in                = PH_IDLE;
            end
         end

         PH_ERROR: begin
            // ignore bytes until restart
            phase_in = PH_ERROR;
         end

         default: begin
            phase_in = PH_ERROR;
         end
      endcase
   end

   // ---------------- state registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         acc_ff      <= '0;
         seen_ff     <= 1'b0;
         body_ff     <= '0;
         tok_left_ff <= '0;
         count_ff    <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         acc_ff      <= acc_in;
         seen_ff     <= seen_in;
         body_ff     <= body_in;
         tok_left_ff <= tok_left_in;
         count_ff    <= count_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // ---------------- length limit register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LengthLimitReset;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

endmodule

### tb/sv/length_prefixed_frame_parser_core_tb.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_core_tb
// checks every rsp word of the frame parser against a byte-level parse
// model kept in the bench; stream bytes come from a short directed list and
// then from random frames, some clean and some damaged, under several
// length limits and with the sender and receiver idling in turns
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lpfp_pkg::*;

   localparam int MaxTokens   = MaxTokensDefault;
   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 6;
   localparam int HoldCycles  = 300;
   localparam int ReportLimit = 10;

   // ways a random frame gets damaged
   typedef enum int {
      FAULT_NONE,
      FAULT_BYTE,
      FAULT_LENGTH,
      FAULT_TRUNCATE,
      FAULT_INSERT,
      FAULT_RESTART
   } fault_kind;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [30:0] csr_data  = '0;

   // stream bytes waiting for the driver, parse results waiting for the dut
   req_type     pending_bytes[$];
   rsp_type     expected_events[$];
   logic [7:0]  frame_bytes[$];

   int bytes_queued   = 0;
   int bytes_taken    = 0;
   int events_checked = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   bit hold_off       = 1'b0;
   bit need_restart   = 1'b0;

   // parse model state, starts at its reset values
   phase_type   parse_state = PH_IDLE;
   logic [30:0] acc_value   = '0;
   logic        have_digit  = 1'b0;
   logic [30:0] body_rem    = '0;
   logic [30:0] tok_rem     = '0;
   logic [8:0]  tok_count   = '0;
   logic [30:0] limit_value = LengthLimitReset;

   length_prefixed_frame_parser_core #(
      .MAX_TOKENS(MaxTokens)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // parse model
   // ------------------------------------------------------------------------

   // any error parks the parser until a byte with restart set
   function automatic rsp_type error_word(input err_type code);
      rsp_type r;
      r = '0;
      r.event_res  = EV_ERROR;
      r.error_code = code;
      parse_state  = PH_ERROR;
      return r;
   endfunction

   // one stream byte in, the parse event it causes out
   function automatic rsp_type parse_byte(input req_type w);
      rsp_type     r;
      logic [7:0]  b;
      logic        is_digit;
      logic [34:0] grown;
      r        = '0;
      b        = w.data_byte;
      is_digit = (b >= CharZero) && (b <= CharNine);
      // accumulator after this digit, wide enough that it cannot wrap
      grown    = {4'd0, acc_value} * 35'd10 + {27'd0, b - CharZero};
      if (w.restart) begin
         parse_state = PH_IDLE;
      end
      case (parse_state)
         PH_IDLE: begin
            if (b != CharHash) begin
               r = error_word(ERR_BAD_START);
            end else begin
               acc_value   = '0;
               have_digit  = 1'b0;
               parse_state = PH_HDR_DIGITS;
            end
         end
         PH_HDR_DIGITS: begin
            if (is_digit) begin
               if (grown > {4'd0, limit_value}) begin
                  r = error_word(ERR_OVER_LIMIT);
               end else begin
                  acc_value  = grown[30:0];
                  have_digit = 1'b1;
               end
            end else if (!have_digit) begin
               r = error_word(ERR_NO_DIGITS);
            end else if (b != CharCr) begin
               r = error_word(ERR_BAD_HDR_END);
            end else begin
               parse_state = PH_HDR_LF;
            end
         end
         PH_HDR_LF: begin
            if (b != CharLf) begin
               r = error_word(ERR_BAD_HDR_END);
            end else if (acc_value < 31'd2) begin
               r = error_word(ERR_BODY_SHORT);
            end else begin
               body_rem    = acc_value;
               tok_count   = '0;
               parse_state = PH_TOK_MARK;
            end
         end
         PH_TOK_MARK: begin
            // only the closing cr lf fits in what is left of the body
            if (body_rem <= 31'd2) begin
               if (b != CharCr) begin
                  r = error_word(ERR_BAD_FRAME_END);
               end else begin
                  body_rem    = 31'd1;
                  parse_state = PH_END_LF;
               end
            end else if (b != CharCaret) begin
               r = error_word(ERR_BAD_TOK_MARK);
            end else begin
               body_rem    = body_rem - 31'd1;
               acc_value   = '0;
               have_digit  = 1'b0;
               parse_state = PH_TOK_DIGITS;
            end
         end
         PH_TOK_DIGITS: begin
            if (body_rem <= 31'd2) begin
               r = error_word(have_digit ? ERR_TOK_TRUNC : ERR_NO_DIGITS);
            end else if (is_digit) begin
               if (grown > {4'd0, limit_value}) begin
                  r = error_word(ERR_OVER_LIMIT);
               end else begin
                  acc_value  = grown[30:0];
                  have_digit = 1'b1;
                  body_rem   = body_rem - 31'd1;
               end
            end else if (!have_digit) begin
               r = error_word(ERR_NO_DIGITS);
            end else if (b != CharAmp) begin
               r = error_word(ERR_BAD_TOK_MARK);
            end else begin
               body_rem = body_rem - 31'd1;
               // token data must leave room for the closing cr lf
               if (acc_value > body_rem - 31'd2) begin
                  r = error_word(ERR_TOK_PAST_BODY);
               end else if (tok_count >= 9'(MaxTokens)) begin
                  r = error_word(ERR_TOO_MANY_TOKS);
               end else begin
                  tok_rem = acc_value;
                  if (tok_rem == '0) begin
                     r.event_res = EV_EMPTY_TOK;
                     r.token_index = tok_count[7:0];
                     tok_count   = tok_count + 9'd1;
                     parse_state = PH_TOK_MARK;
                  end else begin
                     parse_state = PH_TOK_DATA;
                  end
               end
            end
         end
         PH_TOK_DATA: begin
            tok_rem       = tok_rem - 31'd1;
            body_rem      = body_rem - 31'd1;
            r.event_res   = EV_TOKEN_DATA;
            r.token_byte  = b;
            r.token_index = tok_count[7:0];
            if (tok_rem == '0) begin
               r.token_end = 1'b1;
               tok_count   = tok_count + 9'd1;
               parse_state = PH_TOK_MARK;
            end
         end
         PH_END_LF: begin
            if (b != CharLf) begin
               r = error_word(ERR_BAD_FRAME_END);
            end else begin
               body_rem      = '0;
               r.event_res   = EV_FRAME_DONE;
               r.token_count = tok_count;
               parse_state   = PH_IDLE;
            end
         end
         // error state: bytes are dropped with an all-zero framing event
         default: begin
            parse_state = PH_ERROR;
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------------

   function automatic void push_word(input logic [7:0] value, input logic restart_bit);
      req_type w;
      w.data_byte = value;
      w.restart   = restart_bit;
      pending_bytes.push_back(w);
      bytes_queued++;
   endfunction

   function automatic void push_text(input string s, input logic restart_first);
      int k;
      for (k = 0; k < s.len(); k++) begin
         push_word(s[k], restart_first && (k == 0));
      end
   endfunction

   function automatic void push_crlf();
      push_word(CharCr, 1'b0);
      push_word(CharLf, 1'b0);
   endfunction

   // decimal digits into the frame being built, now and then with a leading zero
   function automatic void append_number(input longint unsigned value);
      string digits;
      int    k;
      digits = $sformatf("%0d", value);
      if ($urandom_range(7) == 0) begin
         digits = {"0", digits};
      end
      for (k = 0; k < digits.len(); k++) begin
         frame_bytes.push_back(digits[k]);
      end
   endfunction

   // one random frame, either clean or damaged in one way
   task automatic queue_frame(input bit faulty);
      logic [7:0]      body[$];
      longint unsigned decl_len;
      fault_kind       kind;
      int              n_tok;
      int              tok_len;
      int              pos;
      int              restart_at;
      int              i;
      int              j;
      bit              lead_restart;
      kind       = faulty ? fault_kind'($urandom_range(FAULT_BYTE, FAULT_RESTART))
                          : FAULT_NONE;
      restart_at = -1;
      frame_bytes.delete();
      // mostly a few tokens, sometimes right around the token cap
      if ($urandom_range(7) == 0) begin
         n_tok = $urandom_range(MaxTokens - 1, MaxTokens + 3);
      end else begin
         n_tok = $urandom_range(4);
      end
      for (i = 0; i < n_tok; i++) begin
         tok_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
         frame_bytes.push_back(CharCaret);
         append_number(tok_len);
         frame_bytes.push_back(CharAmp);
         for (j = 0; j < tok_len; j++) begin
            frame_bytes.push_back(8'($urandom_range(255)));
         end
      end
      frame_bytes.push_back(CharCr);
      frame_bytes.push_back(CharLf);
      body     = frame_bytes;
      decl_len = body.size();
      if (kind == FAULT_LENGTH) begin
         // a few off either way, or a wild value that may pass any limit
         if ($urandom_range(3) == 0) begin
            decl_len = $urandom();
         end else begin
            decl_len = decl_len + $urandom_range(6);
            decl_len = (decl_len > 3) ? decl_len - 3 : 0;
         end
      end
      frame_bytes.delete();
      frame_bytes.push_back(CharHash);
      append_number(decl_len);
      frame_bytes.push_back(CharCr);
      frame_bytes.push_back(CharLf);
      foreach (body[i]) begin
         frame_bytes.push_back(body[i]);
      end
      pos = $urandom_range(1, frame_bytes.size() - 1);
      case (kind)
         FAULT_BYTE:     frame_bytes[pos] = 8'($urandom_range(255));
         FAULT_TRUNCATE: frame_bytes = frame_bytes[0:pos - 1];
         FAULT_INSERT:   frame_bytes.insert(pos, 8'($urandom_range(255)));
         FAULT_RESTART:  restart_at = pos;
         default: ;
      endcase
      lead_restart = need_restart || ($urandom_range(3) == 0);
      for (i = 0; i < frame_bytes.size(); i++) begin
         push_word(frame_bytes[i], (i == 0) ? lead_restart : (i == restart_at));
      end
      need_restart = faulty;
   endtask

   // random stream: mostly clean frames, some damaged ones, a little noise
   task automatic queue_stream(input int target);
      int start_count;
      int pick;
      int n_noise;
      int i;
      start_count = bytes_queued;
      while (bytes_queued - start_count < target) begin
         pick = $urandom_range(99);
         if (pick < 72) begin
            queue_frame(1'b0);
         end else if (pick < 92) begin
            queue_frame(1'b1);
         end else begin
            n_noise = $urandom_range(1, 4);
            for (i = 0; i < n_noise; i++) begin
               push_word(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            need_restart = 1'b1;
         end
      end
   endtask

   // wait until every queued byte was taken and its event came back
   task automatic settle();
      while (bytes_taken != bytes_queued || events_checked != bytes_taken) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_length_limit(input logic [30:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid   <= 1'b0;
      limit_value = value;
   endtask

   // ------------------------------------------------------------------------
   // driver: takes words from the pending queue, predicts on acceptance
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_events.push_back(parse_byte(req_data));
            bytes_taken++;
         end
         // a stalled word stays put, otherwise offer the next one or idle
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_bytes.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: compares each rsp word with the oldest predicted event
   // ------------------------------------------------------------------------
   function automatic void compare_field(input string name, input logic [8:0] want,
                                         input logic [8:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= ReportLimit) begin
            $display("mismatch rsp word %0d %s: expected %0d got %0d",
                     events_checked, name, want, got);
         end
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit) begin
                  $display("unexpected rsp word: event %0d", rsp_data.event_res);
               end
            end else begin
               want = expected_events.pop_front();
               compare_field("event_res", 9'(want.event_res), 9'(rsp_data.event_res));
               compare_field("token_byte", 9'(want.token_byte),
                             9'(rsp_data.token_byte));
               compare_field("token_index", 9'(want.token_index),
                             9'(rsp_data.token_index));
               compare_field("token_end", 9'(want.token_end), 9'(rsp_data.token_end));
               compare_field("token_count", want.token_count, rsp_data.token_count);
               compare_field("error_code", 9'(want.error_code),
                             9'(rsp_data.error_code));
               events_checked++;
            end
         end
         rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed bytes at the reset limit, no idling
      push_word("x", 1'b0);                 // bad start from reset
      push_word("A", 1'b0);                 // dropped while in error
      push_text("#", 1'b1);                 // header with no digits
      push_word(CharCr, 1'b0);
      push_text("#1", 1'b1);                // body shorter than cr lf
      push_crlf();
      push_text("#10", 1'b1);               // empty token then a two byte token
      push_crlf();
      push_text("^0&^2&", 1'b0);
      push_word(8'h00, 1'b0);
      push_word(8'hff, 1'b0);
      push_crlf();
      push_text("#2", 1'b0);                // back to back frame with no tokens
      push_crlf();
      push_crlf();
      push_text("#6", 1'b0);                // junk where '&' belongs
      push_crlf();
      push_text("^1x", 1'b0);
      queue_stream(150);
      settle();

      // limit of one: any header length above one is too long
      write_length_limit(31'd1);
      queue_stream(40);
      settle();

      // zero limit: any nonzero length is over
      write_length_limit(31'd0);
      queue_stream(30);
      settle();

      // tight limit, sender mostly idle
      write_length_limit(31'd24);
      send_idle_pct = 88;
      queue_stream(130);
      settle();

      // full limit, receiver mostly stalling
      write_length_limit(LengthLimitReset);
      send_idle_pct = 0;
      stall_pct     = 88;
      queue_stream(130);
      settle();

      // both sides idling now and then
      write_length_limit(31'd60);
      send_idle_pct = 30;
      stall_pct     = 30;
      queue_stream(130);
      settle();

      // receiver holds off for a long stretch while the sender keeps pushing,
      // so the parser pipeline fills up and stalls req
      write_length_limit(31'd200);
      send_idle_pct = 0;
      stall_pct     = 0;
      @(posedge clock);
      fork
         begin
            hold_off <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            hold_off <= 1'b0;
         end
      join_none
      queue_stream(90);
      settle();

      mismatch_count += expected_events.size();
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
